// ===== rtl/masked_byte_pattern_search_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern search unit
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_UNIT_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define MBPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants shared by the masked byte pattern search unit.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int PATTERN_MAX  = 16;
	localparam int WINDOW_DEPTH = 16;
	localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
	localparam int LEN_W        = 5;
	localparam int POS_W        = 33;
	localparam int ADDR_W       = 64;
	localparam int REGION_W     = 32;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_INDEX_W  = 3;
	localparam int PATTERN_W    = 8 * PATTERN_MAX;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_ADDRESS   = 3'd0,
		REG_REGION_SIZE    = 3'd1,
		REG_PATTERN_LOW    = 3'd2,
		REG_PATTERN_HIGH   = 3'd3,
		REG_CARE_MASK      = 3'd4,
		REG_PATTERN_LENGTH = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_scan;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]      base_address;
		logic [REGION_W-1:0]    region_size;
		logic [PATTERN_W-1:0]   pattern;
		logic [PATTERN_MAX-1:0] care_mask;
		logic [LEN_W-1:0]       pattern_length;
	} cfg_t;

	typedef struct packed {
		logic [PATTERN_W-1:0]   pattern;
		logic [PATTERN_MAX-1:0] care_mask;
		logic [LEN_W-1:0]       pattern_length;
	} cell_cfg_t;

endpackage

// ===== rtl/masked_byte_pattern_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_unit
// Streams a memory region byte by byte through a row of window cells and
// reports the address of the first masked pattern match, or a miss.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  cfg       cfg_wr_en               cfg_index, cfg_data
//  in        in_valid / in_ready     in_item (data_byte, start_scan, last_byte)
//  out       out_valid / out_ready   out_item (found, match_address)
//
//  One byte per cycle while in_ready is high; the window cells compare all positions at once.
//  A result passes a compare stage and then an address-add stage after the byte that causes it.
//  in_ready follows out_ready once both stages hold a result; one result may wait in the middle stage.
//  Reset clears scan state, pipeline valids and configuration; no clearing pass.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_unit import mbps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_item
);

	cfg_t                    cfg;
	cell_cfg_t               cell_cfg;
	logic [7:0]              win [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] cell_ok;

	logic                    in_xfer;
	logic [POS_W-1:0]        pos_q;
	logic                    fin_q;
	logic [POS_W-1:0]        pos_eff;
	logic                    fin_eff;
	logic [POS_W-1:0]        pos_next;
	logic [LEN_W-1:0]        len_off;
	logic                    pos_ok;
	logic [POS_W-1:0]        start_idx;
	logic                    in_region;
	logic                    hit;
	logic                    emit;

	logic                    valid_s1;
	logic                    found_s1;
	logic [REGION_W-1:0]     start_s1;
	logic                    adv_s1;

	logic                    out_valid_q;
	logic                    found_q;
	logic [ADDR_W-1:0]       addr_q;

	mbps_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cell_cfg.pattern        = cfg.pattern;
	assign cell_cfg.care_mask      = cfg.care_mask;
	assign cell_cfg.pattern_length = cfg.pattern_length;

	assign in_xfer = in_valid && in_ready;

	genvar k;
	generate
		for (k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
			logic [7:0] byte_in;
			if (k == 0) begin : g_head
				assign byte_in = in_item.data_byte;
			end else begin : g_body
				assign byte_in = win[k-1];
			end
			mbps_cell u_cell (
				.clk        (clk),
				.shift_en   (in_xfer),
				.cell_index (WIN_IDX_W'(k)),
				.cell_cfg   (cell_cfg),
				.byte_in    (byte_in),
				.byte_out   (win[k]),
				.ok         (cell_ok[k])
			);
		end
	endgenerate

	assign pos_eff   = in_item.start_scan ? '0 : pos_q;
	assign fin_eff   = in_item.start_scan ? 1'b0 : fin_q;
	assign pos_next  = (&pos_eff) ? pos_eff : pos_eff + POS_W'(1);
	assign len_off   = (cfg.pattern_length == '0) ? '0 : cfg.pattern_length - LEN_W'(1);
	assign pos_ok    = pos_eff >= {{(POS_W-LEN_W){1'b0}}, len_off};
	assign start_idx = pos_eff - {{(POS_W-LEN_W){1'b0}}, len_off};
	assign in_region = start_idx < {{(POS_W-REGION_W){1'b0}}, cfg.region_size};
	assign hit       = !fin_eff && pos_ok && in_region && (&cell_ok);
	assign emit      = !fin_eff && (hit || in_item.last_byte);

	// scan position and end-of-scan flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fin_q <= 1'b0;
		end else if (in_xfer) begin
			if (fin_eff) begin
				pos_q <= pos_eff;
				fin_q <= 1'b1;
			end else begin
				pos_q <= pos_next;
				fin_q <= emit;
			end
		end
	end

	assign adv_s1   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_xfer && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && emit) begin
			found_s1 <= hit;
			start_s1 <= start_idx[REGION_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			found_q <= found_s1;
			addr_q  <= found_s1 ?
				cfg.base_address + {{(ADDR_W-REGION_W){1'b0}}, start_s1} : '0;
		end
	end

	assign out_valid              = out_valid_q;
	assign out_item.found         = found_q;
	assign out_item.match_address = addr_q;

endmodule

// ===== rtl/mbps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte: holds it, passes it on, compares the incoming byte.
// ----------------------------------------------------------------------------
module mbps_cell import mbps_pkg::*; (
	input  logic                 clk,
	input  logic                 shift_en,
	input  logic [WIN_IDX_W-1:0] cell_index,
	input  cell_cfg_t            cell_cfg,
	input  logic [7:0]           byte_in,
	output logic [7:0]           byte_out,
	output logic                 ok
);

	logic [7:0]           byte_q;
	logic [WIN_IDX_W-1:0] pat_idx;
	logic [7:0]           pat_byte;
	logic                 active;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign active   = {1'b0, cell_index} < cell_cfg.pattern_length;
	assign pat_idx  = cell_cfg.pattern_length[WIN_IDX_W-1:0] - WIN_IDX_W'(1) - cell_index;
	assign pat_byte = cell_cfg.pattern[{pat_idx, 3'b000} +: 8];
	assign ok       = !active || !cell_cfg.care_mask[pat_idx] || (byte_in == pat_byte);

endmodule

// ===== rtl/mbps_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_regs
// Configuration registers with index decode and length saturation.
// ----------------------------------------------------------------------------
module mbps_regs import mbps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t             cfg_q;
	logic [LEN_W-1:0] len_sat;

	assign len_sat = (cfg_data[LEN_W-1:0] > LEN_W'(PATTERN_MAX)) ?
		LEN_W'(PATTERN_MAX) : cfg_data[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address   <= '0;
			cfg_q.region_size    <= '0;
			cfg_q.pattern        <= '0;
			cfg_q.care_mask      <= '1;
			cfg_q.pattern_length <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_BASE_ADDRESS:   cfg_q.base_address <= cfg_data[ADDR_W-1:0];
				REG_REGION_SIZE:    cfg_q.region_size <= cfg_data[REGION_W-1:0];
				REG_PATTERN_LOW:    cfg_q.pattern[63:0] <= cfg_data;
				REG_PATTERN_HIGH:   cfg_q.pattern[127:64] <= cfg_data;
				REG_CARE_MASK:      cfg_q.care_mask <= cfg_data[PATTERN_MAX-1:0];
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= len_sat;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/mbps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks on the search unit, attached by bind.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_search_unit_assert.svh"

module mbps_checker import mbps_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	logic in_xfer;
	logic out_stall;
	logic out_miss;

	assign in_xfer   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_miss  = out_valid && !out_item.found;

	`MBPS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_item), "stalled transfer changed")
	`MBPS_ASSERT_SAME(a_miss_zero, out_miss, out_item.match_address == '0, "miss with address")
	`MBPS_ASSERT_SAME(a_out_cause, $rose(out_valid), $past(in_xfer, 2), "result without input")
	`MBPS_ASSERT_SAME(a_in_open, !out_valid, in_ready, "input blocked with output empty")

endmodule

bind masked_byte_pattern_search_unit mbps_checker u_mbps_checker (.*);

// ===== verif/mbps_scan_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_scan_checker
// Snoops the configuration port and both streaming channels of the masked
// byte pattern search unit. Every accepted byte is run through a local scan
// predictor; every result transfer is compared, field by field, with the
// oldest predicted result.
// ----------------------------------------------------------------------------
module mbps_scan_checker import mbps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  in_item_t               in_item,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  out_item_t              out_item,
	output int                     mismatches,
	output int                     results_pending,
	output int                     bytes_scanned,
	output int                     results_seen,
	output int                     matches_seen
);

	logic [ADDR_W-1:0]      base_address;
	logic [REGION_W-1:0]    region_size;
	logic [PATTERN_W-1:0]   pattern;
	logic [PATTERN_MAX-1:0] care_mask;
	logic [LEN_W-1:0]       pattern_length;

	logic [7:0]             window [WINDOW_DEPTH];
	logic [POS_W-1:0]       scan_pos;
	logic                   scan_done;

	out_item_t              expected_results [$];
	out_item_t              expected_item;
	out_item_t              predicted_item;
	bit                     predicted;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// one byte of the scan: returns the result it causes, if any
	task automatic advance_scan(input in_item_t item, output bit produced,
			output out_item_t result);
		int          k;
		int          eff_len;
		logic [POS_W-1:0] cur;
		logic [POS_W-1:0] cand;
		bit          hit;
		produced = 1'b0;
		result   = '0;
		if (item.start_scan) begin
			scan_pos  = '0;
			scan_done = 1'b0;
		end
		if (scan_done)
			return;
		bytes_scanned++;
		for (k = WINDOW_DEPTH - 1; k > 0; k--)
			window[k] = window[k - 1];
		window[0] = item.data_byte;
		eff_len = (pattern_length > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_length);
		cur = scan_pos;
		if (scan_pos != '1)
			scan_pos = scan_pos + 1'b1;
		if (eff_len == 0 || cur >= POS_W'(eff_len - 1)) begin
			cand = (eff_len == 0) ? cur : cur - POS_W'(eff_len - 1);
			hit  = (cand < {1'b0, region_size});
			for (k = 0; k < eff_len; k++)
				if (care_mask[k] && window[eff_len - 1 - k] != pattern[8*k +: 8])
					hit = 1'b0;
			if (hit) begin
				produced             = 1'b1;
				result.found         = 1'b1;
				result.match_address = base_address + ADDR_W'(cand);
			end
		end
		if (!produced && item.last_byte) begin
			produced             = 1'b1;
			result.found         = 1'b0;
			result.match_address = '0;
		end
		if (produced)
			scan_done = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address   = '0;
			region_size    = '0;
			pattern        = '0;
			care_mask      = '1;
			pattern_length = '0;
			for (int k = 0; k < WINDOW_DEPTH; k++)
				window[k] = '0;
			scan_pos       = '0;
			scan_done      = 1'b0;
			expected_results.delete();
			mismatches      = 0;
			results_pending = 0;
			bytes_scanned   = 0;
			results_seen    = 0;
			matches_seen    = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BASE_ADDRESS:   base_address   = cfg_data;
					REG_REGION_SIZE:    region_size    = cfg_data[REGION_W-1:0];
					REG_PATTERN_LOW:    pattern[63:0]  = cfg_data;
					REG_PATTERN_HIGH:   pattern[127:64] = cfg_data;
					REG_CARE_MASK:      care_mask      = cfg_data[PATTERN_MAX-1:0];
					REG_PATTERN_LENGTH: pattern_length = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_item.found === 1'b1)
					matches_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result found=%b address=%h",
						out_item.found, out_item.match_address));
				end else begin
					expected_item = expected_results.pop_front();
					if (out_item.found !== expected_item.found)
						report_mismatch($sformatf("found: got %b, want %b",
							out_item.found, expected_item.found));
					if (out_item.match_address !== expected_item.match_address)
						report_mismatch($sformatf("match_address: got %h, want %h",
							out_item.match_address, expected_item.match_address));
				end
			end
			if (in_valid && in_ready) begin
				advance_scan(in_item, predicted, predicted_item);
				if (predicted)
					expected_results.push_back(predicted_item);
			end
			results_pending = expected_results.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the masked byte pattern search unit with directed scans (reset
// defaults, saturated and zero lengths, don't-care bytes, address wrap) and
// then random configuration phases of planted, broken and noisy scans, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import mbps_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam int BYTE_TARGET   = 350;

	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_B = 3'd7;

	typedef enum int {SCAN_WELL_FORMED, SCAN_BROKEN, SCAN_NOISE} scan_kind_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	in_item_t               in_item;
	logic                   out_valid;
	logic                   out_ready;
	out_item_t              out_item;

	int mismatches;
	int results_pending;
	int bytes_scanned;
	int results_seen;
	int matches_seen;
	int items_sent = 0;
	int idle_cycles = 0;
	int phases = 0;
	bit hold_req = 1'b0;
	bit gaps_on = 1'b1;
	bit spare_toggle = 1'b0;

	logic [31:0]  cur_region = '0;
	logic [127:0] cur_pat    = '0;
	logic [15:0]  cur_care   = 16'hFFFF;
	logic [4:0]   cur_len    = '0;

	masked_byte_pattern_search_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	mbps_scan_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_item         (in_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_item        (out_item),
		.mismatches      (mismatches),
		.results_pending (results_pending),
		.bytes_scanned   (bytes_scanned),
		.results_seen    (results_seen),
		.matches_seen    (matches_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// hold valid and payload until the transfer edge
	task automatic send_byte(input logic [7:0] data, input logic first, input logic final_byte);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{data_byte: data, start_scan: first, last_byte: final_byte};
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [63:0] base, input logic [31:0] region,
			input logic [127:0] pat, input logic [15:0] care, input logic [4:0] len);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_BASE_ADDRESS;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= REG_REGION_SIZE;
		cfg_data  <= {$urandom, region};
		@(posedge clk);
		cfg_index <= REG_PATTERN_LOW;
		cfg_data  <= pat[63:0];
		@(posedge clk);
		cfg_index <= REG_PATTERN_HIGH;
		cfg_data  <= pat[127:64];
		@(posedge clk);
		cfg_index <= REG_CARE_MASK;
		cfg_data  <= {$urandom, 16'($urandom), care};
		@(posedge clk);
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data  <= {$urandom, 27'($urandom), len};
		@(posedge clk);
		// unlisted index: must leave every register alone
		cfg_index <= spare_toggle ? SPARE_INDEX_B : SPARE_INDEX_A;
		cfg_data  <= {$urandom, $urandom};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		spare_toggle = ~spare_toggle;
		cur_region = region;
		cur_pat    = pat;
		cur_care   = care;
		cur_len    = len;
		phases++;
	endtask

	task automatic stream_scan(input scan_kind_t kind);
		logic [7:0] bytes [64];
		int         n;
		int         eff_len;
		int         plant_at;
		int         i;
		logic       first;
		logic       final_byte;
		eff_len = (cur_len > PATTERN_MAX) ? PATTERN_MAX : int'(cur_len);
		if (kind == SCAN_WELL_FORMED && cur_region <= 24)
			n = int'(cur_region) + eff_len - 1;
		else
			n = $urandom_range(1, 40);
		if (n < 1)
			n = 1;
		if (n > 64)
			n = 64;
		// bias the content towards pattern bytes so partial matches occur
		for (i = 0; i < n; i++)
			bytes[i] = ($urandom_range(0, 1) != 0) ? 8'($urandom)
				: cur_pat[8*$urandom_range(0, PATTERN_MAX - 1) +: 8];
		if (eff_len > 0 && n >= eff_len && $urandom_range(0, 3) != 0) begin
			plant_at = $urandom_range(0, n - eff_len);
			for (i = 0; i < eff_len; i++)
				if (cur_care[i])
					bytes[plant_at + i] = cur_pat[8*i +: 8];
		end
		for (i = 0; i < n; i++) begin
			case (kind)
				SCAN_NOISE: begin
					first      = ($urandom_range(0, 7) == 0);
					final_byte = ($urandom_range(0, 7) == 0);
				end
				SCAN_BROKEN: begin
					first      = (i == 0);
					final_byte = 1'b0;
				end
				default: begin
					first      = (i == 0);
					final_byte = (i == n - 1);
				end
			endcase
			send_byte(bytes[i], first, final_byte);
		end
	endtask

	// receiver: random runs and stalls, plus one long hold-off on request
	initial begin : receiver
		int unsigned run_left;
		int unsigned stall_left;
		int unsigned r;
		run_left   = 0;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
				run_left   = 0;
			end else if (stall_left == 0 && run_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					run_left = $urandom_range(1, 30);
				else if (r < 90)
					stall_left = $urandom_range(1, 3);
				else
					stall_left = $urandom_range(10, 40);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (run_left > 0)
					run_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [63:0]  r_base;
		logic [31:0]  r_region;
		logic [127:0] r_pat;
		logic [15:0]  r_care;
		logic [4:0]   r_len;
		int unsigned  scans;
		int unsigned  i;
		int unsigned  r;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_BASE_ADDRESS;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, no start seen yet: both final bytes report a miss
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h5A, 1'b0, 1'b1);
		send_byte(8'hA5, 1'b1, 1'b1);
		drain();

		// oversized length saturates; all-ones bytes at the top of the address space
		apply_config('1, 32'd1, '1, 16'hFFFF, 5'd31);
		for (i = 0; i < PATTERN_MAX; i++)
			send_byte(8'hFF, i == 0, i == PATTERN_MAX - 1);
		drain();

		// empty pattern hits on the first byte; the next one is dropped
		apply_config(64'h0, 32'hFFFF_FFFF, '0, 16'hFFFF, 5'd0);
		send_byte(8'h3C, 1'b1, 1'b0);
		send_byte(8'hC3, 1'b0, 1'b1);
		drain();

		// address wraps past the top
		apply_config('1, 32'd2, '0, 16'h0001, 5'd1);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		drain();

		// no care bits: any window matches
		apply_config(64'h1000, 32'd1, {$urandom, $urandom, $urandom, $urandom}, 16'h0000, 5'd2);
		send_byte(8'h12, 1'b1, 1'b0);
		send_byte(8'h34, 1'b0, 1'b1);
		drain();

		// back-pressure: one result per byte while the output is held off
		apply_config({$urandom, $urandom}, 32'd4, '0, 16'hFFFF, 5'd0);
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 40; i++)
			send_byte(8'($urandom), 1'b1, 1'($urandom));
		drain();

		while (items_sent < BYTE_TARGET) begin
			r = $urandom_range(0, 7);
			r_base = (r == 0) ? '1 : (r == 1) ? '0 : (r == 2) ? '1 - 64'($urandom_range(0, 15))
				: {$urandom, $urandom};
			r = $urandom_range(0, 9);
			r_region = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'd0 : $urandom_range(1, 20);
			r_pat  = {$urandom, $urandom, $urandom, $urandom};
			r_care = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom);
			r_len  = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(0, PATTERN_MAX));
			apply_config(r_base, r_region, r_pat, r_care, r_len);
			gaps_on = ($urandom_range(0, 3) != 0);
			scans = $urandom_range(3, 8);
			for (i = 0; i < scans; i++) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					stream_scan(SCAN_NOISE);
				else if (r == 1)
					stream_scan(SCAN_BROKEN);
				else
					stream_scan(SCAN_WELL_FORMED);
			end
			drain();
		end

		$display("summary: %0d bytes sent, %0d scanned, over %0d configuration phases",
			items_sent, bytes_scanned, phases);
		$display("summary: %0d results checked, %0d of them matches", results_seen,
			matches_seen);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
